/* rtl/bqf_pkg.sv */
package bqf_pkg;

  // Field widths of the sample and coefficient words.
  localparam int SampleBits = 24;
  localparam int CoefBits   = 24;

  // Coefficients are Q2.x and the gain is Q4.x.
  localparam int CFrac = CoefBits - 2;
  localparam int GFrac = CoefBits - 4;

  // A full product, and an accumulator with headroom for five products and rounding.
  localparam int ProdBits = SampleBits + CoefBits;
  localparam int AccBits  = ProdBits + 3;

  localparam int CfgIdxBits = 3;

  localparam logic [CoefBits-1:0] GainReset = CoefBits'(1) << GFrac;
  localparam logic [AccBits-1:0]  AccRound  = AccBits'(1) << (CFrac - 1);
  localparam logic [AccBits-1:0]  GainRound = AccBits'(1) << (GFrac - 1);

  localparam logic signed [AccBits-1:0] SatMax =
      {{(AccBits - SampleBits + 1){1'b0}}, {(SampleBits - 1){1'b1}}};
  localparam logic signed [AccBits-1:0] SatMin =
      {{(AccBits - SampleBits + 1){1'b1}}, {(SampleBits - 1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } bqf_reg_e;

  // Operand pair that the shared multiplier works on.
  typedef enum logic [2:0] {
    TERM_GAIN,
    TERM_B0,
    TERM_B1,
    TERM_B2,
    TERM_A1,
    TERM_A2
  } bqf_term_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN_MUL,
    ST_GAIN_RND,
    ST_MAC,
    ST_FLUSH,
    ST_FINISH
  } bqf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_x;
    logic      mul_en;
    bqf_term_e term;
    logic      gain_rnd;
    logic      acc_clr;
    logic      acc_add;
    logic      finish;
  } bqf_cmd_t;

  // Floor division is done by the caller; this clamps to the sample range.
  function automatic logic signed [SampleBits-1:0] sat_sample(
      input logic signed [AccBits-1:0] v);
    logic signed [SampleBits-1:0] r;
    if (v > SatMax) begin
      r = SatMax[SampleBits-1:0];
    end else if (v < SatMin) begin
      r = SatMin[SampleBits-1:0];
    end else begin
      r = v[SampleBits-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/bqf_in_if.sv */
interface bqf_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bqf_pkg::SampleBits-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

/* rtl/bqf_out_if.sv */
interface bqf_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bqf_pkg::SampleBits-1:0]  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

/* rtl/biquad_bandpass_filter.sv */
// Direct form I biquad on signed 24-bit words. Each input word is scaled by
// the Q4.20 gain, rounded and clamped, then filtered with the Q2.22
// coefficients b0, b1, b2, a1 and a2 (already normalized by a0); the output is
// rounded half up and saturated, and the clamped values are what the history
// keeps. One shared 24x24 multiplier with a wide accumulator does all six
// products in turn. A new word is accepted only after the previous one has
// reached the output register. A finished word waits in the output register
// while the next word is taken and computed. Coefficients must be written
// through the index/data port only while the filter is idle; the block itself
// does not enforce this. Writes to indexes 6 and 7 are ignored.
module biquad_bandpass_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bqf_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [bqf_pkg::CoefBits-1:0]    cfg_data_i,
  bqf_in_if.sink                          in_ch_i,
  bqf_out_if.source                       out_ch_o
);

  bqf_pkg::bqf_cmd_t cmd;

  // Sequencer for the shared multiply-accumulate.
  bqf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .cmd_o       (cmd)
  );

  // Coefficients, history, multiplier and accumulator.
  bqf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sample_in_i  (in_ch_i.sample_in),
    .sample_out_o (out_ch_o.sample_out)
  );

endmodule

/* rtl/bqf_datapath.sv */
module bqf_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bqf_pkg::CfgIdxBits-1:0]         cfg_idx_i,
  input  logic [bqf_pkg::CoefBits-1:0]           cfg_data_i,
  input  bqf_pkg::bqf_cmd_t                      cmd_i,
  input  logic signed [bqf_pkg::SampleBits-1:0]  sample_in_i,
  output logic signed [bqf_pkg::SampleBits-1:0]  sample_out_o
);

  logic signed [bqf_pkg::CoefBits-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q, gain_q;
  logic signed [bqf_pkg::SampleBits-1:0] x_q, xg_q, x1_q, x2_q, y1_q, y2_q;
  logic signed [bqf_pkg::SampleBits-1:0] out_q;
  logic signed [bqf_pkg::SampleBits-1:0] mul_a;
  logic signed [bqf_pkg::CoefBits-1:0]   mul_b;
  logic signed [bqf_pkg::ProdBits-1:0]   prod_d, prod_q;
  logic                                  prod_neg_q;
  logic signed [bqf_pkg::AccBits-1:0]    prod_ext, acc_q, gain_sum;
  logic signed [bqf_pkg::SampleBits-1:0] xg_d, y_d;

  // Coefficient registers; writes to unknown indexes fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= '0;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      gain_q <= bqf_pkg::GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bqf_pkg::REG_B0:   b0_q   <= cfg_data_i;
        bqf_pkg::REG_B1:   b1_q   <= cfg_data_i;
        bqf_pkg::REG_B2:   b2_q   <= cfg_data_i;
        bqf_pkg::REG_A1:   a1_q   <= cfg_data_i;
        bqf_pkg::REG_A2:   a2_q   <= cfg_data_i;
        bqf_pkg::REG_GAIN: gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (cmd_i.term)
      bqf_pkg::TERM_GAIN: begin mul_a = x_q;  mul_b = gain_q; end
      bqf_pkg::TERM_B0:   begin mul_a = xg_q; mul_b = b0_q;   end
      bqf_pkg::TERM_B1:   begin mul_a = x1_q; mul_b = b1_q;   end
      bqf_pkg::TERM_B2:   begin mul_a = x2_q; mul_b = b2_q;   end
      bqf_pkg::TERM_A1:   begin mul_a = y1_q; mul_b = a1_q;   end
      bqf_pkg::TERM_A2:   begin mul_a = y2_q; mul_b = a2_q;   end
      default:            begin mul_a = x_q;  mul_b = gain_q; end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Registered product; feedback terms are remembered as subtractions.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q     <= prod_d;
      prod_neg_q <= (cmd_i.term == bqf_pkg::TERM_A1) || (cmd_i.term == bqf_pkg::TERM_A2);
    end
  end

  assign prod_ext = {{(bqf_pkg::AccBits - bqf_pkg::ProdBits){prod_q[bqf_pkg::ProdBits-1]}},
                     prod_q};

  // Scaled input: round half up, floor, then clamp.
  assign gain_sum = prod_ext + signed'(bqf_pkg::GainRound);
  assign xg_d     = bqf_pkg::sat_sample(gain_sum >>> bqf_pkg::GFrac);

  // Filter output from the accumulator, which already holds the rounding term.
  assign y_d = bqf_pkg::sat_sample(acc_q >>> bqf_pkg::CFrac);

  // Input word, scaled input, accumulator and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.gain_rnd) begin
      xg_q <= xg_d;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= signed'(bqf_pkg::AccRound);
    end else if (cmd_i.acc_add) begin
      acc_q <= prod_neg_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
    if (cmd_i.finish) begin
      out_q <= y_d;
    end
  end

  // Filter history shifts once per finished word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (cmd_i.finish) begin
      x2_q <= x1_q;
      x1_q <= xg_q;
      y2_q <= y1_q;
      y1_q <= y_d;
    end
  end

  assign sample_out_o = out_q;

endmodule

/* rtl/bqf_ctrl.sv */
module bqf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bqf_pkg::bqf_cmd_t  cmd_o
);

  bqf_pkg::bqf_state_e state_q, state_d;
  bqf_pkg::bqf_term_e  term_q, term_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and term counter.
  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    unique case (state_q)
      bqf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bqf_pkg::ST_GAIN_MUL;
        end
      end
      bqf_pkg::ST_GAIN_MUL: begin
        state_d = bqf_pkg::ST_GAIN_RND;
      end
      bqf_pkg::ST_GAIN_RND: begin
        state_d = bqf_pkg::ST_MAC;
        term_d  = bqf_pkg::TERM_B0;
      end
      bqf_pkg::ST_MAC: begin
        unique case (term_q)
          bqf_pkg::TERM_B0: term_d = bqf_pkg::TERM_B1;
          bqf_pkg::TERM_B1: term_d = bqf_pkg::TERM_B2;
          bqf_pkg::TERM_B2: term_d = bqf_pkg::TERM_A1;
          bqf_pkg::TERM_A1: term_d = bqf_pkg::TERM_A2;
          default: begin
            term_d  = bqf_pkg::TERM_B0;
            state_d = bqf_pkg::ST_FLUSH;
          end
        endcase
      end
      bqf_pkg::ST_FLUSH: begin
        state_d = bqf_pkg::ST_FINISH;
      end
      bqf_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = bqf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bqf_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o          = '0;
    cmd_o.term     = bqf_pkg::TERM_GAIN;
    in_ready_o     = 1'b0;
    unique case (state_q)
      bqf_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.load_x = in_valid_i;
      end
      bqf_pkg::ST_GAIN_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      bqf_pkg::ST_GAIN_RND: begin
        cmd_o.gain_rnd = 1'b1;
        cmd_o.acc_clr  = 1'b1;
      end
      bqf_pkg::ST_MAC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.term    = term_q;
        cmd_o.acc_add = (term_q != bqf_pkg::TERM_B0);
      end
      bqf_pkg::ST_FLUSH: begin
        cmd_o.acc_add = 1'b1;
      end
      bqf_pkg::ST_FINISH: begin
        cmd_o.finish = out_free;
      end
      default: ;
    endcase
  end

  // Output word valid flag: set by a finished word, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bqf_pkg::ST_IDLE;
      term_q      <= bqf_pkg::TERM_B0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.finish |=> out_valid_q)
    else $error("finished word did not raise output valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before it was taken");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o) |=> (state_q == bqf_pkg::ST_GAIN_MUL))
    else $error("accepted word did not start the gain multiply");

  a_flush_after_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == bqf_pkg::ST_FLUSH) |-> ($past(state_q) == bqf_pkg::ST_MAC))
    else $error("accumulator flush without a preceding multiply pass");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  typedef logic signed [bqf_pkg::SampleBits-1:0] word_t;
  typedef logic signed [bqf_pkg::CoefBits-1:0]   coef_t;

  // Indexes that decode to no register.
  localparam logic [bqf_pkg::CfgIdxBits-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [bqf_pkg::CfgIdxBits-1:0] REG_SPARE_7 = 3'd7;

  localparam word_t WORD_MAX = {1'b0, {(bqf_pkg::SampleBits - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(bqf_pkg::SampleBits - 1){1'b0}}};
  localparam coef_t COEF_MAX = {1'b0, {(bqf_pkg::CoefBits - 1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(bqf_pkg::CoefBits - 1){1'b0}}};
  localparam coef_t COEF_ONE = coef_t'(1) <<< bqf_pkg::CFrac;
  localparam coef_t COEF_HALF = coef_t'(1) <<< (bqf_pkg::CFrac - 1);
  localparam coef_t GAIN_HALF = coef_t'(1) <<< (bqf_pkg::GFrac - 1);

  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 12;
  localparam int WORDS_PER_PHASE = 137;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           cfg_we   = 1'b0;
  logic [bqf_pkg::CfgIdxBits-1:0] cfg_idx  = '0;
  logic [bqf_pkg::CoefBits-1:0]   cfg_data = '0;

  logic  drv_valid  = 1'b0;
  word_t drv_sample = '0;
  logic  mon_ready  = 1'b0;

  bqf_in_if  in_ch ();
  bqf_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.sample_in = drv_sample;
  assign out_ch.ready    = mon_ready;

  biquad_bandpass_filter dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_ch_i   (in_ch),
    .out_ch_o  (out_ch)
  );

  always #4 clk_i = ~clk_i;

  // Filter settings and history as the block should hold them.
  coef_t b0_q = '0, b1_q = '0, b2_q = '0, a1_q = '0, a2_q = '0;
  coef_t gain_q = bqf_pkg::GainReset;
  word_t hist_in_1 = '0, hist_in_2 = '0, hist_out_1 = '0, hist_out_2 = '0;

  word_t pending_words[$];
  word_t expected_words[$];

  bit bursts_on = 1'b1;
  bit long_hold_req = 1'b0;
  int fail_count = 0;
  int words_checked = 0;
  int cycle_count = 0;

  // Clamp a wide value to the signed sample range.
  function automatic word_t clamp_word(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bqf_pkg::SampleBits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return word_t'(hi);
    if (v < lo) return word_t'(lo);
    return word_t'(v);
  endfunction

  // Scale one input word, run it through the biquad and advance the history.
  function automatic word_t filter_word(word_t x);
    longint scaled;
    longint acc;
    word_t  xg;
    word_t  y;
    scaled = longint'(x) * longint'(gain_q) + (longint'(1) <<< (bqf_pkg::GFrac - 1));
    xg = clamp_word(scaled >>> bqf_pkg::GFrac);
    acc = longint'(b0_q) * longint'(xg)
        + longint'(b1_q) * longint'(hist_in_1)
        + longint'(b2_q) * longint'(hist_in_2)
        - longint'(a1_q) * longint'(hist_out_1)
        - longint'(a2_q) * longint'(hist_out_2)
        + (longint'(1) <<< (bqf_pkg::CFrac - 1));
    y = clamp_word(acc >>> bqf_pkg::CFrac);
    hist_in_2  = hist_in_1;
    hist_in_1  = xg;
    hist_out_2 = hist_out_1;
    hist_out_1 = y;
    return y;
  endfunction

  // Input driver: offers queued words with random idle bursts.
  logic  nxt_valid;
  word_t nxt_sample;
  int    send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_sample <= '0;
      send_gap = 0;
    end else begin
      nxt_valid  = drv_valid;
      nxt_sample = drv_sample;
      if (drv_valid && in_ch.ready) begin
        expected_words.push_back(filter_word(drv_sample));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 16) - 1;
        end else if (pending_words.size() > 0) begin
          nxt_sample = pending_words.pop_front();
          nxt_valid  = 1'b1;
        end
      end
      drv_valid  <= nxt_valid;
      drv_sample <= nxt_sample;
    end
  end

  // Output monitor: checks each word against the oldest prediction.
  logic  nxt_ready;
  word_t want_word;
  int    hold_left;
  int    stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_ready <= 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && mon_ready) begin
        if (expected_words.size() == 0) begin
          $error("sample_out: no word expected, actual %0d", out_ch.sample_out);
          fail_count++;
        end else begin
          want_word = expected_words.pop_front();
          words_checked++;
          if (out_ch.sample_out !== want_word) begin
            $error("sample_out: expected %0d, actual %0d", want_word, out_ch.sample_out);
            fail_count++;
          end
        end
      end
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      nxt_ready = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        nxt_ready = 1'b0;
      end
      mon_ready <= nxt_ready;
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One register write, mirrored into the predicted settings.
  task automatic write_reg(logic [bqf_pkg::CfgIdxBits-1:0] idx, coef_t data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      bqf_pkg::REG_B0:   b0_q = data;
      bqf_pkg::REG_B1:   b1_q = data;
      bqf_pkg::REG_B2:   b2_q = data;
      bqf_pkg::REG_A1:   a1_q = data;
      bqf_pkg::REG_A2:   a2_q = data;
      bqf_pkg::REG_GAIN: gain_q = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic program_filter(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2,
                                coef_t gain);
    write_reg(bqf_pkg::REG_B0, b0);
    write_reg(bqf_pkg::REG_B1, b1);
    write_reg(bqf_pkg::REG_B2, b2);
    write_reg(bqf_pkg::REG_A1, a1);
    write_reg(bqf_pkg::REG_A2, a2);
    write_reg(bqf_pkg::REG_GAIN, gain);
  endtask

  // Wait until every queued word is accepted and every output has arrived.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || drv_valid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic word_t random_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return word_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic coef_t random_gain();
    if ($urandom_range(0, 3) == 0) return coef_t'($urandom);
    return coef_t'($urandom_range(GAIN_HALF / 2, 4 * GAIN_HALF));
  endfunction

  function automatic coef_t pick_extreme();
    return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
  endfunction

  // Stimulus.
  initial begin
    int p;
    int n;
    int a2_val;
    int a1_lim;
    int a1_val;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: all coefficients zero, so every output is zero.
    pending_words.push_back(WORD_MAX);
    pending_words.push_back(WORD_MIN);
    pending_words.push_back(word_t'(1));
    settle();

    // Pass-through with unit gain, then writes to the undecoded indexes.
    program_filter(COEF_ONE, '0, '0, '0, '0, bqf_pkg::GainReset);
    write_reg(REG_SPARE_6, COEF_MAX);
    write_reg(REG_SPARE_7, COEF_MIN);
    pending_words.push_back(WORD_MAX);
    pending_words.push_back(WORD_MIN);
    pending_words.push_back('1);
    pending_words.push_back(word_t'(1));
    settle();

    // Largest and smallest gain: the scaled input saturates.
    write_reg(bqf_pkg::REG_GAIN, COEF_MAX);
    pending_words.push_back(WORD_MAX);
    pending_words.push_back(WORD_MIN);
    settle();
    write_reg(bqf_pkg::REG_GAIN, COEF_MIN);
    pending_words.push_back(WORD_MIN);
    pending_words.push_back(WORD_MAX);
    settle();

    // Extreme coefficients drive the filter sum out of range.
    program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, bqf_pkg::GainReset);
    pending_words.push_back(WORD_MAX);
    pending_words.push_back(WORD_MAX);
    pending_words.push_back(WORD_MIN);
    settle();

    // Exact halves in both rounding steps go toward plus infinity.
    program_filter(COEF_ONE, '0, '0, '0, '0, GAIN_HALF);
    pending_words.push_back(word_t'(1));
    pending_words.push_back('1);
    settle();
    program_filter(COEF_HALF, '0, '0, '0, '0, bqf_pkg::GainReset);
    pending_words.push_back(word_t'(3));
    pending_words.push_back(word_t'(-3));
    settle();

    // Random phases, each under its own filter setting.
    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          // Stable random poles with moderate zeros.
          a2_val = int'($urandom_range(0, 7969178)) - 3984589;
          a1_lim = ((4194304 + a2_val) * 95) / 100;
          a1_val = int'($urandom_range(0, 2 * a1_lim)) - a1_lim;
          program_filter(coef_t'(int'($urandom_range(0, 4194304)) - 2097152),
                         coef_t'(int'($urandom_range(0, 4194304)) - 2097152),
                         coef_t'(int'($urandom_range(0, 4194304)) - 2097152),
                         coef_t'(a1_val), coef_t'(a2_val), random_gain());
        end
        1: begin
          // A band-pass design, with its zeros at DC and at half the sample rate.
          program_filter(coef_t'(629146), '0, coef_t'(-629146), coef_t'(-5326766),
                         coef_t'(2936013), random_gain());
        end
        2: begin
          program_filter(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                         coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
          write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, coef_t'($urandom));
        end
        default: begin
          program_filter(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                         pick_extreme(), pick_extreme());
        end
      endcase
      bursts_on = (p < PHASES - 2) && (p % 5 != 4);
      for (n = 0; n < WORDS_PER_PHASE; n++) pending_words.push_back(random_word());
      if (p == 2) begin
        // Hold the output off while the sender keeps offering words.
        @(negedge clk_i);
        long_hold_req = 1'b1;
      end
      settle();
    end

    if (expected_words.size() != 0) begin
      $error("sample_out: %0d expected words never arrived", expected_words.size());
      fail_count++;
    end
    $display("Checked %0d output words over %0d directed and %0d random filter settings.",
             words_checked, 7, PHASES);
    $display("Covered saturation, half-up rounding, extreme gains and undecoded writes.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* biquad_bandpass_filter.f */
rtl/bqf_pkg.sv
rtl/bqf_in_if.sv
rtl/bqf_out_if.sv
rtl/bqf_datapath.sv
rtl/bqf_ctrl.sv
rtl/biquad_bandpass_filter.sv
tb/tb.sv
